[src/utr_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// Package for the USB host transaction retry block.
// Holds the item, state, configuration and result types and the fixed codes.
package utr_pkg;

  typedef enum logic [1:0] {
    MODE_START = 2'd0,
    MODE_TICK  = 2'd1,
    MODE_DONE  = 2'd2,
    MODE_NONE  = 2'd3
  } mode_t;

  // Register indexes on the configuration port.
  localparam logic [1:0] CFG_DEADLINE     = 2'd0;
  localparam logic [1:0] CFG_NAK_BUDGET   = 2'd1;
  localparam logic [1:0] CFG_RETRY_BUDGET = 2'd2;

  // Handshake result codes.
  localparam logic [3:0] NAK_CODE         = 4'd4;
  localparam logic [3:0] BUS_TIMEOUT_CODE = 4'd14;
  localparam logic [3:0] NO_DONE_CODE     = 4'hf;

  localparam logic [15:0] DEADLINE_RST     = 16'd5000;
  localparam logic [15:0] NAK_BUDGET_RST   = 16'd32000;
  localparam logic [7:0]  RETRY_BUDGET_RST = 8'd3;

  typedef struct packed {
    mode_t      mode;
    logic [3:0] token_code;
    logic [3:0] endpoint_address;
    logic [3:0] handshake_result;
  } item_t;

  typedef struct packed {
    logic [15:0] deadline_ms;
    logic [15:0] nak_budget;
    logic [7:0]  retry_budget;
  } cfg_t;

  typedef struct packed {
    logic        active;
    logic [7:0]  held_word;
    logic [15:0] ms_remaining;
    logic [15:0] nak_seen;
    logic [7:0]  timeouts_seen;
  } xact_t;

  typedef struct packed {
    logic       launch;
    logic [7:0] launch_word;
    logic       finished;
    logic [3:0] final_result;
    logic       timed_out;
    logic       busy_res;
  } result_t;

endpackage

`default_nettype wire

[src/usb_host_transfer_retry.sv]
`timescale 1ns / 1ps
`default_nettype none
// Top level of the USB host transaction retry sequencer.
// Depends on utr_pkg, utr_cfg and utr_step.
//
// This block sequences one USB host transaction at a time. A start transaction
// latches the token and endpoint into a launch word, loads the millisecond
// deadline, clears the NAK and bus-timeout counters and issues the launch word.
// Tick transactions count the deadline down; when it runs out while a transfer
// is in flight the transaction ends with timed_out set and a final result of
// 0xF. A completion transaction carries the handshake result: a NAK or bus
// timeout relaunches the same word until its budget is reached, and any other
// result ends the transaction at once. Every input transaction yields exactly
// one result transaction. Each item is held in the input register and then
// passes through the update logic into the output register, and a new item is
// accepted every cycle while out_stall does not hold the output register; the
// throughput is then one item per clock. The output register lets the next
// item be taken while a finished result still waits on out_stall.
// Configuration registers are written through the cfg port, which is always
// ready, and should only be changed while no transaction is in the pipeline.
module usb_host_transfer_retry (
  input  wire logic        clk,
  input  wire logic        rst_n,

  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [1:0]  in_mode,
  input  wire logic [3:0]  in_token_code,
  input  wire logic [3:0]  in_endpoint_address,
  input  wire logic [3:0]  in_handshake_result,

  output logic             out_valid,
  input  wire logic        out_stall,
  output logic             out_launch,
  output logic [7:0]       out_launch_word,
  output logic             out_finished,
  output logic [3:0]       out_final_result,
  output logic             out_timed_out,
  output logic             out_busy_res,

  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [15:0] cfg_data
);
  import utr_pkg::*;

  cfg_t    cfg;
  item_t   s1_item_r;
  logic    s1_valid_r;
  xact_t   xact_r;
  xact_t   xact_nxt;
  result_t step_res;
  result_t out_res_r;
  logic    out_valid_r;
  logic    advance;

  utr_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  utr_step u_step (
    .item (s1_item_r),
    .cfg  (cfg),
    .cur  (xact_r),
    .nxt  (xact_nxt),
    .res  (step_res)
  );

  // The output register can take a new result when it is empty or being drained.
  assign advance  = !out_valid_r || !out_stall;
  // The input register is free when it is empty or its item moves on this cycle.
  assign in_stall = s1_valid_r && !advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (!in_stall) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_item_r <= '{mode:             mode_t'(in_mode),
                     token_code:       in_token_code,
                     endpoint_address: in_endpoint_address,
                     handshake_result: in_handshake_result};
    end
  end

  // Transaction state commits as the item moves into the output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      xact_r <= '0;
    end else if (s1_valid_r && advance) begin
      xact_r <= xact_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_valid_r && advance) begin
      out_res_r <= step_res;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_launch       = out_res_r.launch;
  assign out_launch_word  = out_res_r.launch_word;
  assign out_finished     = out_res_r.finished;
  assign out_final_result = out_res_r.final_result;
  assign out_timed_out    = out_res_r.timed_out;
  assign out_busy_res     = out_res_r.busy_res;

endmodule

`default_nettype wire

[src/utr_cfg.sv]
`timescale 1ns / 1ps
`default_nettype none
// Configuration register file for the transaction retry block.
// Depends on utr_pkg for the register indexes and reset values.
module utr_cfg (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         cfg_valid,
  output logic              cfg_ready,
  input  wire logic [1:0]   cfg_index,
  input  wire logic [15:0]  cfg_data,
  output utr_pkg::cfg_t     cfg
);
  import utr_pkg::*;

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  assign cfg_ready = 1'b1;
  assign cfg      = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      case (cfg_index)
        CFG_DEADLINE:     cfg_nxt.deadline_ms  = cfg_data;
        CFG_NAK_BUDGET:   cfg_nxt.nak_budget   = cfg_data;
        CFG_RETRY_BUDGET: cfg_nxt.retry_budget = cfg_data[7:0];
        default:          cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.deadline_ms  <= DEADLINE_RST;
      cfg_r.nak_budget   <= NAK_BUDGET_RST;
      cfg_r.retry_budget <= RETRY_BUDGET_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

`default_nettype wire

[src/utr_step.sv]
`timescale 1ns / 1ps
`default_nettype none
// Next-state and result logic for one transaction item.
// Depends on utr_pkg for the item, state, configuration and result types.
module utr_step (
  input  utr_pkg::item_t   item,
  input  utr_pkg::cfg_t    cfg,
  input  utr_pkg::xact_t   cur,
  output utr_pkg::xact_t   nxt,
  output utr_pkg::result_t res
);
  import utr_pkg::*;

  logic [15:0] nak_inc;
  logic [7:0]  tmo_inc;
  logic        done;

  assign nak_inc = (cur.nak_seen == 16'hffff) ? cur.nak_seen : cur.nak_seen + 16'd1;
  assign tmo_inc = (cur.timeouts_seen == 8'hff) ? cur.timeouts_seen
                                                : cur.timeouts_seen + 8'd1;

  always_comb begin
    nxt  = cur;
    res  = '0;
    done = 1'b1;
    case (item.mode)
      MODE_START: begin
        nxt.held_word     = {item.token_code, item.endpoint_address};
        nxt.ms_remaining  = cfg.deadline_ms;
        nxt.nak_seen      = '0;
        nxt.timeouts_seen = '0;
        nxt.active        = 1'b1;
        res.launch        = 1'b1;
        res.launch_word   = {item.token_code, item.endpoint_address};
      end
      MODE_TICK: begin
        if (cur.active) begin
          if (cur.ms_remaining <= 16'd1) begin
            nxt.ms_remaining = '0;
            nxt.active       = 1'b0;
            res.finished     = 1'b1;
            res.timed_out    = 1'b1;
            res.final_result = NO_DONE_CODE;
          end else begin
            nxt.ms_remaining = cur.ms_remaining - 16'd1;
          end
        end
      end
      MODE_DONE: begin
        if (cur.active) begin
          // A NAK takes precedence should both codes ever coincide.
          if (item.handshake_result == NAK_CODE) begin
            nxt.nak_seen = nak_inc;
            done = (nak_inc >= cfg.nak_budget);
          end else if (item.handshake_result == BUS_TIMEOUT_CODE) begin
            nxt.timeouts_seen = tmo_inc;
            done = (tmo_inc >= cfg.retry_budget);
          end
          if (done) begin
            nxt.active       = 1'b0;
            res.finished     = 1'b1;
            res.final_result = item.handshake_result;
          end else begin
            res.launch      = 1'b1;
            res.launch_word = cur.held_word;
          end
        end
      end
      default: begin
        nxt = cur;
      end
    endcase
    res.busy_res = nxt.active;
  end

endmodule

`default_nettype wire

[sim/tb_usb_host_transfer_retry.sv]
`timescale 1ns / 1ps
// Self-checking testbench for the USB host transaction retry sequencer.
// Depends on utr_pkg and usb_host_transfer_retry; drives items, configures the
// budgets and compares every result against an in-bench transaction predictor.
module tb_usb_host_transfer_retry;
  import utr_pkg::*;

  // The slowest correct run is far below this. About 1150 items, each waiting
  // out receiver stalls, plus the long hold-off, still finish well inside it.
  localparam int unsigned CYCLE_LIMIT = 400000;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic [1:0]  in_mode;
  logic [3:0]  in_token_code;
  logic [3:0]  in_endpoint_address;
  logic [3:0]  in_handshake_result;
  logic        out_valid;
  logic        out_stall;
  logic        out_launch;
  logic [7:0]  out_launch_word;
  logic        out_finished;
  logic [3:0]  out_final_result;
  logic        out_timed_out;
  logic        out_busy_res;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [1:0]  cfg_index;
  logic [15:0] cfg_data;

  usb_host_transfer_retry dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_mode             (in_mode),
    .in_token_code       (in_token_code),
    .in_endpoint_address (in_endpoint_address),
    .in_handshake_result (in_handshake_result),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_launch          (out_launch),
    .out_launch_word     (out_launch_word),
    .out_finished        (out_finished),
    .out_final_result    (out_final_result),
    .out_timed_out       (out_timed_out),
    .out_busy_res        (out_busy_res),
    .cfg_valid           (cfg_valid),
    .cfg_ready           (cfg_ready),
    .cfg_index           (cfg_index),
    .cfg_data            (cfg_data)
  );

  // The predictor keeps its own copy of the transaction state and of the three
  // budget registers. Both are updated at the clock edge where the matching
  // input or configuration transaction is accepted.
  xact_t   xact;
  cfg_t    budgets;
  result_t pending_results[$];

  // Idle rates in percent for the sender and the receiver, and the request for
  // a long receiver hold-off that the stall process below counts down itself.
  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;
  int unsigned hold_request;
  int unsigned hold_left;

  int unsigned error_count;
  int unsigned cycle_count;
  int unsigned items_sent;
  int unsigned live_items;
  int unsigned results_seen;
  int unsigned finishes_seen;
  int unsigned expiries_seen;
  int unsigned relaunches_seen;
  int unsigned cfg_writes;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Next state and result of the sequencer for one accepted item.
  function automatic result_t predict_result(input item_t it);
    result_t r;
    logic    done;
    r = '0;
    done = 1'b1;
    case (it.mode)
      MODE_START: begin
        // A start always wins, even over a transaction that is still running.
        xact.held_word     = {it.token_code, it.endpoint_address};
        xact.ms_remaining  = budgets.deadline_ms;
        xact.nak_seen      = '0;
        xact.timeouts_seen = '0;
        xact.active        = 1'b1;
        r.launch           = 1'b1;
        r.launch_word      = xact.held_word;
      end
      MODE_TICK: begin
        if (xact.active) begin
          if (xact.ms_remaining <= 16'd1) begin
            xact.ms_remaining = '0;
            xact.active       = 1'b0;
            r.finished        = 1'b1;
            r.timed_out       = 1'b1;
            r.final_result    = NO_DONE_CODE;
          end else begin
            xact.ms_remaining = xact.ms_remaining - 16'd1;
          end
        end
      end
      MODE_DONE: begin
        if (xact.active) begin
          // Both retry counters saturate rather than wrap.
          if (it.handshake_result == NAK_CODE) begin
            if (xact.nak_seen != 16'hffff) xact.nak_seen = xact.nak_seen + 16'd1;
            done = xact.nak_seen >= budgets.nak_budget;
          end else if (it.handshake_result == BUS_TIMEOUT_CODE) begin
            if (xact.timeouts_seen != 8'hff) xact.timeouts_seen = xact.timeouts_seen + 8'd1;
            done = xact.timeouts_seen >= budgets.retry_budget;
          end
          if (done) begin
            xact.active    = 1'b0;
            r.finished     = 1'b1;
            r.final_result = it.handshake_result;
          end else begin
            r.launch      = 1'b1;
            r.launch_word = xact.held_word;
          end
        end
      end
      default: begin
      end
    endcase
    r.busy_res = xact.active;
    return r;
  endfunction

  // Offers one item and returns at the edge where it is accepted. The valid
  // stays high on return, so that a following call can keep it asserted
  // without lowering and raising it in the same time step.
  task automatic send_item(input mode_t m, input logic [3:0] tok, input logic [3:0] addr,
                           input logic [3:0] res);
    item_t it;
    it = '{mode: m, token_code: tok, endpoint_address: addr, handshake_result: res};
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid            <= 1'b1;
    in_mode             <= m;
    in_token_code       <= tok;
    in_endpoint_address <= addr;
    in_handshake_result <= res;
    do @(posedge clk); while (in_stall);
    items_sent++;
    // Ticks and completions while idle, and the unused mode, do nothing.
    if (m == MODE_START || ((m == MODE_TICK || m == MODE_DONE) && xact.active))
      live_items++;
    pending_results.push_back(predict_result(it));
  endtask

  // Stops offering items and waits until every predicted result has come back,
  // plus the depth of the input and output registers with some margin.
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Writes all three budget registers back to back. The block must be idle.
  task automatic write_budgets(input logic [15:0] deadline, input logic [15:0] naks,
                               input logic [7:0] retries);
    logic [1:0]  idx [3];
    logic [15:0] val [3];
    idx = '{CFG_DEADLINE, CFG_NAK_BUDGET, CFG_RETRY_BUDGET};
    val = '{deadline, naks, {8'h00, retries}};
    for (int i = 0; i < 3; i++) begin
      cfg_valid <= 1'b1;
      cfg_index <= idx[i];
      cfg_data  <= val[i];
      do @(posedge clk); while (!cfg_ready);
      cfg_writes++;
      case (idx[i])
        CFG_DEADLINE:     budgets.deadline_ms  = val[i];
        CFG_NAK_BUDGET:   budgets.nak_budget   = val[i];
        CFG_RETRY_BUDGET: budgets.retry_budget = val[i][7:0];
        default: begin
        end
      endcase
    end
    cfg_valid <= 1'b0;
  endtask

  // Budgets for the random part: small most of the time so that every limit
  // is actually reached, and now and then the largest value.
  task automatic write_random_budgets();
    logic [15:0] deadline;
    logic [15:0] naks;
    logic [7:0]  retries;
    deadline = ($urandom_range(9) == 0) ? 16'hffff : 16'($urandom_range(1, 40));
    naks     = ($urandom_range(9) == 0) ? 16'hffff : 16'($urandom_range(1, 10));
    retries  = ($urandom_range(9) == 0) ? 8'hff : 8'($urandom_range(1, 6));
    write_budgets(deadline, naks, retries);
  endtask

  // One well-formed transaction: a start with random content, then ticks and
  // completion reports until the transaction ends or forty steps are sent. A few
  // restarts and unused mode items are mixed in to hit those paths mid-transfer.
  task automatic send_transaction();
    int unsigned steps;
    int unsigned pick;
    logic [3:0]  res;
    steps = 0;
    send_item(MODE_START, 4'($urandom), 4'($urandom), 4'($urandom));
    while (xact.active && steps < 40) begin
      pick = $urandom_range(99);
      if (pick < 3) begin
        send_item(MODE_START, 4'($urandom), 4'($urandom), 4'($urandom));
      end else if (pick < 6) begin
        send_item(MODE_NONE, 4'($urandom), 4'($urandom), 4'($urandom));
      end else if (pick < 40) begin
        send_item(MODE_TICK, 4'($urandom), 4'($urandom), 4'($urandom));
      end else begin
        pick = $urandom_range(99);
        if (pick < 45) res = NAK_CODE;
        else if (pick < 75) res = BUS_TIMEOUT_CODE;
        else res = 4'($urandom);
        send_item(MODE_DONE, 4'($urandom), 4'($urandom), res);
      end
      steps++;
    end
  endtask

  task automatic test_reset_defaults();
    // Nothing is running yet, so tick, completion and the unused mode are ignored.
    send_item(MODE_TICK,  4'h0, 4'h0, 4'h0);
    send_item(MODE_DONE,  4'h0, 4'h0, NAK_CODE);
    send_item(MODE_NONE,  4'hf, 4'hf, 4'hf);
    // Largest launch word; the reset retry budget of three bus timeouts ends it.
    send_item(MODE_START, 4'hf, 4'hf, 4'h0);
    send_item(MODE_TICK,  4'h0, 4'h0, 4'h0);
    send_item(MODE_NONE,  4'h0, 4'h0, 4'h0);
    send_item(MODE_DONE,  4'h0, 4'h0, BUS_TIMEOUT_CODE);
    send_item(MODE_DONE,  4'h0, 4'h0, BUS_TIMEOUT_CODE);
    send_item(MODE_DONE,  4'h0, 4'h0, BUS_TIMEOUT_CODE);
    // Smallest launch word, one NAK, then a restart drops it without a finish.
    send_item(MODE_START, 4'h0, 4'h0, 4'hf);
    send_item(MODE_DONE,  4'hf, 4'hf, NAK_CODE);
    send_item(MODE_START, 4'ha, 4'h5, 4'h0);
    send_item(MODE_DONE,  4'h0, 4'h0, 4'h0);
    wait_drained();
  endtask

  task automatic test_budget_extremes();
    // Budgets of one: every limit is hit on its first event.
    write_budgets(16'd1, 16'd1, 8'd1);
    send_item(MODE_START, 4'h9, 4'h3, 4'h0);
    send_item(MODE_TICK,  4'h0, 4'h0, 4'h0);
    send_item(MODE_START, 4'h1, 4'h2, 4'h0);
    send_item(MODE_DONE,  4'h0, 4'h0, NAK_CODE);
    send_item(MODE_START, 4'h4, 4'h8, 4'h0);
    send_item(MODE_DONE,  4'h0, 4'h0, BUS_TIMEOUT_CODE);
    wait_drained();
    // Zero budgets behave like budgets of one.
    write_budgets(16'd0, 16'd0, 8'd0);
    send_item(MODE_START, 4'h6, 4'hc, 4'h0);
    send_item(MODE_TICK,  4'h0, 4'h0, 4'h0);
    send_item(MODE_START, 4'h3, 4'h7, 4'h0);
    send_item(MODE_DONE,  4'h0, 4'h0, NAK_CODE);
    wait_drained();
    // Largest budgets: retries relaunch, and result 0xF ends without a timeout.
    write_budgets(16'hffff, 16'hffff, 8'hff);
    send_item(MODE_START, 4'hc, 4'h1, 4'h0);
    send_item(MODE_DONE,  4'h0, 4'h0, NAK_CODE);
    send_item(MODE_TICK,  4'h0, 4'h0, 4'h0);
    send_item(MODE_DONE,  4'h0, 4'h0, 4'hf);
    wait_drained();
  endtask

  // Random traffic under one idle setting, with the budgets changed halfway.
  task automatic test_random_traffic(input int unsigned send_pct, input int unsigned recv_pct,
                                     input int unsigned count);
    int unsigned goal;
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    for (int half = 0; half < 2; half++) begin
      write_random_budgets();
      goal = live_items + count / 2;
      while (live_items < goal) begin
        if ($urandom_range(99) < 85) begin
          send_transaction();
        end else begin
          send_item(mode_t'($urandom_range(3)), 4'($urandom), 4'($urandom), 4'($urandom));
        end
      end
      wait_drained();
    end
  endtask

  // The receiver holds off for a long stretch while the sender keeps offering,
  // so the output and input registers fill and the block stalls its input.
  task automatic test_backpressure();
    int unsigned goal;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    write_budgets(16'd30, 16'd6, 8'd4);
    hold_request = 200;
    goal = live_items + 60;
    while (live_items < goal) send_transaction();
    wait_drained();
  endtask

  // The receiver stalls at random, or for a long stretch when asked to.
  always @(posedge clk) begin
    if (hold_request != 0) begin
      hold_left    = hold_request - 1;
      hold_request = 0;
      out_stall   <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  task automatic check_field(input string name, input int unsigned want, input int unsigned got);
    if (want != got) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      error_count++;
    end
  endtask

  // Each accepted result transaction is compared with the oldest prediction.
  always @(posedge clk) begin
    result_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        $error("result transaction arrived with no prediction waiting");
        error_count++;
      end else begin
        want = pending_results.pop_front();
        results_seen++;
        if (want.finished) finishes_seen++;
        if (want.timed_out) expiries_seen++;
        if (want.launch) relaunches_seen++;
        check_field("launch",       want.launch,       out_launch);
        check_field("launch_word",  want.launch_word,  out_launch_word);
        check_field("finished",     want.finished,     out_finished);
        check_field("final_result", want.final_result, out_final_result);
        check_field("timed_out",    want.timed_out,    out_timed_out);
        check_field("busy_res",     want.busy_res,     out_busy_res);
      end
    end
  end

  // Watchdog: a hung handshake ends the run as a failure.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles with %0d results outstanding",
               cycle_count, pending_results.size());
      $display("status: fail");
      $finish;
    end
  end

  initial begin
    xact            = '0;
    budgets         = '{deadline_ms: DEADLINE_RST, nak_budget: NAK_BUDGET_RST,
                        retry_budget: RETRY_BUDGET_RST};
    send_idle_pct   = 0;
    recv_idle_pct   = 0;
    hold_request    = 0;
    hold_left       = 0;
    error_count     = 0;
    cycle_count     = 0;
    items_sent      = 0;
    live_items      = 0;
    results_seen    = 0;
    finishes_seen   = 0;
    expiries_seen   = 0;
    relaunches_seen = 0;
    cfg_writes      = 0;

    rst_n               <= 1'b0;
    in_valid            <= 1'b0;
    in_mode             <= MODE_START;
    in_token_code       <= '0;
    in_endpoint_address <= '0;
    in_handshake_result <= '0;
    cfg_valid           <= 1'b0;
    cfg_index           <= CFG_DEADLINE;
    cfg_data            <= '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed checks run first, the first with the reset budgets still in place.
    test_reset_defaults();
    test_budget_extremes();

    // Random traffic: a slow receiver, a slow sender, a long hold-off, full rate.
    test_random_traffic(9, 73, 380);
    test_random_traffic(73, 9, 380);
    test_backpressure();
    test_random_traffic(0, 0, 330);

    wait_drained();
    repeat (8) @(posedge clk);

    $display("Sent %0d input transactions (%0d active) across %0d register writes.",
             items_sent, live_items, cfg_writes);
    $display("Checked %0d results: %0d launches, %0d finishes, %0d deadline expiries.",
             results_seen, relaunches_seen, finishes_seen, expiries_seen);
    if (error_count == 0 && pending_results.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("%0d mismatches, %0d predictions never matched",
               error_count, pending_results.size());
      $display("status: fail");
    end
    $finish;
  end

endmodule

[filelist.f]
src/utr_pkg.sv
src/utr_cfg.sv
src/utr_step.sv
src/usb_host_transfer_retry.sv
sim/tb_usb_host_transfer_retry.sv
